@@ rtl/eant_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eant_pkg
// Shared types and codes for the expiring address name table.
// ----------------------------------------------------------------------------
package eant_pkg;

    localparam int unsigned LIFETIME_W = 31;
    localparam logic [LIFETIME_W-1:0] LIFETIME_RESET = 31'd3600;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAN  = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_REFRESHED = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FULL      = 3'd2,
        ST_FOUND     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_CLEANED   = 3'd5,
        ST_SKIPPED   = 3'd6,
        ST_UNUSED    = 3'd7
    } status_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [15:0] name_ref;
        logic [31:0] time_now;
    } request_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] found_name_ref;
        logic [10:0] removed_count;
        logic [10:0] entry_count;
    } response_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the request
        logic scan_rst;  // restart scan at slot 0
        logic scan_step; // evaluate the slot read last cycle, advance
        logic clean_ok;  // commit last clean time
        logic finish;    // build the response
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic init_done;
        logic clean_run;
    } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/eant_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eant_datapath
// Entry storage, scan counter and per-request bookkeeping.
// ----------------------------------------------------------------------------
module eant_datapath #(
    parameter int unsigned TABLE_DEPTH = 1024,
    parameter int unsigned IDX_W       = 10,
    parameter int unsigned CNT_W       = 11
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  eant_pkg::dp_cmd_t         cmd,
    output eant_pkg::dp_stat_t        stat,
    input  eant_pkg::request_t        req,
    input  wire [eant_pkg::LIFETIME_W-1:0] lifetime,
    output eant_pkg::response_t       resp
);
    import eant_pkg::*;

    // memories: one read and one write per cycle
    logic [127:0] addr_mem  [TABLE_DEPTH];
    logic [15:0]  name_mem  [TABLE_DEPTH];
    logic [32:0]  exp_mem   [TABLE_DEPTH];
    logic         valid_mem [TABLE_DEPTH];

    request_t       req_reg;
    logic [32:0]    expiry_reg;
    logic [CNT_W-1:0] count_reg, removed_reg;
    logic [31:0]    last_clean_reg;
    logic [IDX_W:0] scan_reg;      // slot being read
    logic [IDX_W:0] clr_reg;       // slot cleared by the pass after reset
    logic           rd_vld_reg;    // read data valid for rd_idx_reg
    logic [IDX_W-1:0] rd_idx_reg;
    logic [127:0]   rd_addr_reg;
    logic [15:0]    rd_name_reg;
    logic [32:0]    rd_exp_reg;
    logic           rd_vbit_reg;
    logic           hit_reg, free_reg;
    logic [IDX_W-1:0] hit_idx_reg, free_idx_reg;
    logic [15:0]    hit_name_reg;
    response_t      resp_reg, resp_next;

    logic rd_valid, match, expired, clearing, insert;
    assign rd_valid = rd_vld_reg && rd_vbit_reg;
    assign match    = rd_valid && rd_addr_reg == {req_reg.address_high, req_reg.address_low};
    assign expired  = rd_valid && rd_exp_reg < {1'b0, req_reg.time_now};
    assign clearing = clr_reg != (IDX_W+1)'(TABLE_DEPTH);
    assign insert   = req_reg.opcode == OP_ADD && !hit_reg && free_reg
                      && count_reg < CNT_W'(TABLE_DEPTH);

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= addr_mem[scan_reg[IDX_W-1:0]];
        rd_name_reg <= name_mem[scan_reg[IDX_W-1:0]];
        rd_exp_reg  <= exp_mem[scan_reg[IDX_W-1:0]];
        rd_vbit_reg <= valid_mem[scan_reg[IDX_W-1:0]];
        if (clearing)
            valid_mem[clr_reg[IDX_W-1:0]] <= 1'b0;
        else if (cmd.scan_step && stat.clean_run && expired)
            valid_mem[rd_idx_reg] <= 1'b0;
        else if (cmd.finish && insert)
            valid_mem[free_idx_reg] <= 1'b1;
        if (cmd.finish && req_reg.opcode == OP_ADD)
        begin
            if (hit_reg)
                exp_mem[hit_idx_reg] <= expiry_reg;
            else if (insert)
            begin
                exp_mem[free_idx_reg]  <= expiry_reg;
                addr_mem[free_idx_reg] <= {req_reg.address_high, req_reg.address_low};
                name_mem[free_idx_reg] <= req_reg.name_ref;
            end
        end
        if (cmd.load)
        begin
            req_reg    <= req;
            expiry_reg <= {1'b0, req.time_now} + {2'b0, lifetime};
        end
    end

    always_comb
    begin
        resp_next = '0;
        resp_next.entry_count = 11'(count_reg);
        case (req_reg.opcode)
            OP_ADD:
            begin
                if (hit_reg)
                    resp_next.status = ST_REFRESHED;
                else if (insert)
                begin
                    resp_next.status = ST_INSERTED;
                    resp_next.entry_count = 11'(count_reg + 1'b1);
                end
                else
                    resp_next.status = ST_FULL;
            end
            OP_SEARCH:
            begin
                resp_next.status = hit_reg ? ST_FOUND : ST_NOT_FOUND;
                resp_next.found_name_ref = hit_reg ? hit_name_reg : 16'd0;
            end
            OP_CLEAN:
            begin
                resp_next.status = stat.clean_run ? ST_CLEANED : ST_SKIPPED;
                resp_next.removed_count = stat.clean_run ? 11'(removed_reg) : 11'd0;
            end
            default:
            begin
                resp_next.status = ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            removed_reg    <= '0;
            last_clean_reg <= '0;
            scan_reg       <= '0;
            clr_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            rd_idx_reg     <= '0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            hit_idx_reg    <= '0;
            free_idx_reg   <= '0;
            hit_name_reg   <= '0;
            resp_reg       <= '0;
        end
        else
        begin
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            if (cmd.scan_rst)
            begin
                scan_reg    <= '0;
                rd_vld_reg  <= 1'b0;
                hit_reg     <= 1'b0;
                free_reg    <= 1'b0;
                removed_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                // advance the read pointer; the last read drains in the next cycle
                if (scan_reg != (IDX_W+1)'(TABLE_DEPTH))
                    scan_reg <= scan_reg + 1'b1;
                rd_vld_reg <= scan_reg != (IDX_W+1)'(TABLE_DEPTH);
                rd_idx_reg <= scan_reg[IDX_W-1:0];
                if (rd_vld_reg)
                begin
                    if (match && !hit_reg)
                    begin
                        hit_reg      <= 1'b1;
                        hit_idx_reg  <= rd_idx_reg;
                        hit_name_reg <= rd_name_reg;
                    end
                    if (!rd_vbit_reg && !free_reg)
                    begin
                        free_reg     <= 1'b1;
                        free_idx_reg <= rd_idx_reg;
                    end
                    if (stat.clean_run && expired)
                    begin
                        removed_reg <= removed_reg + 1'b1;
                        if (count_reg != '0)
                            count_reg <= count_reg - 1'b1;
                    end
                end
            end
            if (cmd.clean_ok)
                last_clean_reg <= req_reg.time_now;
            if (cmd.finish)
            begin
                resp_reg <= resp_next;
                if (insert)
                    count_reg <= count_reg + 1'b1;
            end
        end
    end

    assign stat.scan_done = scan_reg == (IDX_W+1)'(TABLE_DEPTH) && !rd_vld_reg;
    assign stat.init_done = !clearing;
    assign stat.clean_run = req_reg.opcode == OP_CLEAN && req_reg.time_now > last_clean_reg;
    assign resp = resp_reg;

endmodule
`default_nettype wire

@@ rtl/eant_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// eant_ctrl
// Sequencer: accept a request, sweep the table, hand off the response.
// ----------------------------------------------------------------------------
module eant_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire                 out_ready,
    output eant_pkg::dp_cmd_t   cmd,
    input  eant_pkg::dp_stat_t  stat
);
    import eant_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_INIT, S_SCAN, S_DONE} state_t;
    state_t state_reg;
    logic   out_valid_reg;

    // a finished response may still wait while the next request is taken
    assign in_ready  = state_reg == S_IDLE && stat.init_done;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd = '0;
        cmd.load      = state_reg == S_IDLE && stat.init_done && in_valid;
        cmd.scan_rst  = state_reg == S_INIT;
        cmd.scan_step = state_reg == S_SCAN;
        cmd.finish    = state_reg == S_DONE && (!out_valid_reg || out_ready);
        cmd.clean_ok  = cmd.finish && stat.clean_run;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (cmd.load) state_reg <= S_INIT;
                S_INIT: state_reg <= S_SCAN;
                S_SCAN: if (stat.scan_done) state_reg <= S_DONE;
                S_DONE:
                begin
                    if (cmd.finish)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/expiring_address_name_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// expiring_address_name_table_core
// IPv6 address to name-handle table with expiry, add/search/clean requests.
// ----------------------------------------------------------------------------
// Every request sweeps all TABLE_DEPTH slots through one memory read port,
// one slot a cycle, and the response is presented once the sweep is done. One
// request is in flight at a time; a finished response waits in an output
// register while the next request is taken. After reset the block clears its
// valid bits with in_ready held low. The entry lifetime register sits at
// address 0.
// ----------------------------------------------------------------------------
module expiring_address_name_table_core #(
    parameter int unsigned TABLE_DEPTH = 1024
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  eant_pkg::request_t   in_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output eant_pkg::response_t  out_data,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire [1:0]            paddr,
    input  wire [31:0]           pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import eant_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned CNT_W = IDX_W + 1;

    logic [LIFETIME_W-1:0] lifetime_reg;
    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {1'b0, lifetime_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lifetime_reg <= LIFETIME_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0)
            lifetime_reg <= pwdata[LIFETIME_W-1:0];
    end

    eant_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    eant_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .req      (in_data),
        .lifetime (lifetime_reg),
        .resp     (out_data)
    );

endmodule
`default_nettype wire
